// File: rtl/core/cdte_pkg.sv
package cdte_pkg;

   localparam int unsigned YEAR_W = 13;
   localparam int unsigned MS_W   = 43;
   localparam int unsigned PC_W   = 4;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = 13'd1970;
   localparam logic [3:0]        MONTH_LAST = 4'd13;

   localparam logic [MS_W-1:0] MS_PER_DAY    = 43'd86400000;
   localparam logic [MS_W-1:0] MS_PER_HOUR   = 43'd3600000;
   localparam logic [MS_W-1:0] MS_PER_MINUTE = 43'd60000;
   localparam logic [MS_W-1:0] MS_PER_SECOND = 43'd1000;
   localparam logic [MS_W-1:0] MS_DAY_BACK   = ~MS_PER_DAY + 43'd1;
   localparam logic [MS_W-1:0] MS_YEAR_365   = 43'd31536000000;
   localparam logic [MS_W-1:0] MS_YEAR_366   = 43'd31622400000;

   // sequencer branch conditions
   localparam logic [2:0] COND_START = 3'd0;
   localparam logic [2:0] COND_NEXT  = 3'd1;
   localparam logic [2:0] COND_YEAR  = 3'd2;
   localparam logic [2:0] COND_MONTH = 3'd3;
   localparam logic [2:0] COND_DONE  = 3'd4;

   // addend sources
   localparam logic [3:0] SRC_NONE     = 4'd0;
   localparam logic [3:0] SRC_YEAR     = 4'd1;
   localparam logic [3:0] SRC_MONTH    = 4'd2;
   localparam logic [3:0] SRC_DAY      = 4'd3;
   localparam logic [3:0] SRC_DAY_BACK = 4'd4;
   localparam logic [3:0] SRC_HOUR     = 4'd5;
   localparam logic [3:0] SRC_MINUTE   = 4'd6;
   localparam logic [3:0] SRC_SECOND   = 4'd7;
   localparam logic [3:0] SRC_MILLI    = 4'd8;

   // program steps
   localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] STEP_YEARS  = 4'd1;
   localparam logic [PC_W-1:0] STEP_MONTHS = 4'd2;
   localparam logic [PC_W-1:0] STEP_DAY    = 4'd3;
   localparam logic [PC_W-1:0] STEP_BACK   = 4'd4;
   localparam logic [PC_W-1:0] STEP_HOUR   = 4'd5;
   localparam logic [PC_W-1:0] STEP_MINUTE = 4'd6;
   localparam logic [PC_W-1:0] STEP_SECOND = 4'd7;
   localparam logic [PC_W-1:0] STEP_MILLI  = 4'd8;

   typedef struct packed {
      logic [2:0] cond;
      logic [3:0] src;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      unique case (pc)
         STEP_IDLE:   w = '{cond: COND_START, src: SRC_NONE};
         STEP_YEARS:  w = '{cond: COND_YEAR,  src: SRC_YEAR};
         STEP_MONTHS: w = '{cond: COND_MONTH, src: SRC_MONTH};
         STEP_DAY:    w = '{cond: COND_NEXT,  src: SRC_DAY};
         STEP_BACK:   w = '{cond: COND_NEXT,  src: SRC_DAY_BACK};
         STEP_HOUR:   w = '{cond: COND_NEXT,  src: SRC_HOUR};
         STEP_MINUTE: w = '{cond: COND_NEXT,  src: SRC_MINUTE};
         STEP_SECOND: w = '{cond: COND_NEXT,  src: SRC_SECOND};
         STEP_MILLI:  w = '{cond: COND_DONE,  src: SRC_MILLI};
         default:     w = '{cond: COND_DONE,  src: SRC_NONE};
      endcase
      return w;
   endfunction

   // gregorian rule; divide by 100 as multiply by reciprocal, exact below 43690
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [25:0]       prod;
      logic [6:0]        q;
      logic [YEAR_W-1:0] r;
      prod = 26'(y) * 26'd5243;
      q    = prod[25:19];
      r    = y - 13'(q) * 13'd100;
      return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
   endfunction

   // whole month length in ms, common year, month one-based
   function automatic logic [MS_W-1:0] month_ms(input logic [3:0] m);
      logic [4:0] d;
      unique case (m)
         4'd2:                   d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default:                d = 5'd31;
      endcase
      return 43'(d) * MS_PER_DAY;
   endfunction

endpackage

// File: rtl/core/civil_date_to_epoch_ms_unit.sv
// civil UTC date and time to milliseconds since 1970-01-01 00:00:00
// input: a transfer is taken when start is high and busy is low; the req_
//    fields are captured at that edge and need not be held afterwards
// config: csr_write_data is the century base, written when csr_write_enable
//    is high; write it only while busy is low. reset value is 2000
// output: rsp_valid is high for one cycle with rsp_epoch_ms; the receiver
//    cannot stall, so nothing is ever held back
// sequence: a year loop, one year per cycle through the shared adder, then a
//    month loop, then the day, day back, hour, minute, second and milli steps
// throughput: one item at a time; busy falls in the cycle rsp_valid rises,
//    so the next item can be taken there
// reset: idles the sequencer, clears the strobe and sets the century base
//    back to 2000
module civil_date_to_epoch_ms_unit
   import cdte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [4:0]       req_day_of_month,
   input  logic [3:0]       req_month_number,
   input  logic [6:0]       req_two_digit_year,
   input  logic [4:0]       req_hour_of_day,
   input  logic [5:0]       req_minute_of_hour,
   input  logic [5:0]       req_second_of_minute,
   input  logic [9:0]       req_millisecond_part,
   input  logic             csr_write_enable,
   input  logic [11:0]      csr_write_data,
   output logic             rsp_valid,
   output logic [MS_W-1:0]  rsp_epoch_ms
);

   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [11:0]       base_ff, base_in;
   logic              valid_ff, valid_in;
   logic [MS_W-1:0]   result_ff, result_in;
   logic [MS_W-1:0]   acc_ff, acc_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [YEAR_W-1:0] target_year_ff, target_year_in;
   logic [3:0]        month_ff, month_in;
   logic [3:0]        mcnt_ff, mcnt_in;
   logic [4:0]        day_ff, day_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        minute_ff, minute_in;
   logic [5:0]        second_ff, second_in;
   logic [9:0]        milli_ff, milli_in;

   ctrl_word_type     cw;
   logic              year_more;
   logic              month_more;
   logic [MS_W-1:0]   addend;
   logic [MS_W-1:0]   sum;

   assign cw         = ucode(pc_ff);
   assign year_more  = year_ff < target_year_ff;
   assign month_more = mcnt_ff < month_ff;

   always_comb begin
      unique case (cw.src)
         SRC_YEAR:     addend = !year_more ? '0 :
                                (is_leap(year_ff) ? MS_YEAR_366 : MS_YEAR_365);
         SRC_MONTH:    addend = !month_more ? '0 :
                                month_ms(mcnt_ff) +
                                (((mcnt_ff == 4'd2) && is_leap(target_year_ff)) ?
                                 MS_PER_DAY : '0);
         SRC_DAY:      addend = 43'(day_ff) * MS_PER_DAY;
         SRC_DAY_BACK: addend = MS_DAY_BACK;
         SRC_HOUR:     addend = 43'(hour_ff) * MS_PER_HOUR;
         SRC_MINUTE:   addend = 43'(minute_ff) * MS_PER_MINUTE;
         SRC_SECOND:   addend = 43'(second_ff) * MS_PER_SECOND;
         SRC_MILLI:    addend = 43'(milli_ff);
         default:      addend = '0;
      endcase
   end

   assign sum = acc_ff + addend;

   always_comb begin
      pc_in          = pc_ff;
      base_in        = csr_write_enable ? csr_write_data : base_ff;
      valid_in       = 1'b0;
      result_in      = result_ff;
      acc_in         = sum;
      year_in        = year_ff;
      target_year_in = target_year_ff;
      month_in       = month_ff;
      mcnt_in        = mcnt_ff;
      day_in         = day_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      milli_in       = milli_ff;
      unique case (cw.cond)
         COND_START: begin
            acc_in = '0;
            if (start) begin
               pc_in          = pc_ff + 4'd1;
               year_in        = EPOCH_YEAR;
               target_year_in = 13'(base_ff) + 13'(req_two_digit_year);
               month_in       = (req_month_number > MONTH_LAST) ? MONTH_LAST
                                                                : req_month_number;
               mcnt_in        = 4'd1;
               day_in         = req_day_of_month;
               hour_in        = req_hour_of_day;
               minute_in      = req_minute_of_hour;
               second_in      = req_second_of_minute;
               milli_in       = req_millisecond_part;
            end
         end
         COND_YEAR: begin
            if (year_more) begin
               year_in = year_ff + 13'd1;
            end else begin
               pc_in = pc_ff + 4'd1;
            end
         end
         COND_MONTH: begin
            if (month_more) begin
               mcnt_in = mcnt_ff + 4'd1;
            end else begin
               pc_in = pc_ff + 4'd1;
            end
         end
         COND_NEXT: begin
            pc_in = pc_ff + 4'd1;
         end
         COND_DONE: begin
            pc_in     = STEP_IDLE;
            valid_in  = 1'b1;
            result_in = sum;
         end
         default: begin
            pc_in = STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= STEP_IDLE;
         base_ff  <= 12'd2000;
         valid_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         base_ff  <= base_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff      <= result_in;
      acc_ff         <= acc_in;
      year_ff        <= year_in;
      target_year_ff <= target_year_in;
      month_ff       <= month_in;
      mcnt_ff        <= mcnt_in;
      day_ff         <= day_in;
      hour_ff        <= hour_in;
      minute_ff      <= minute_in;
      second_ff      <= second_in;
      milli_ff       <= milli_in;
   end

   assign busy         = pc_ff != STEP_IDLE;
   assign rsp_valid    = valid_ff;
   assign rsp_epoch_ms = result_ff;

endmodule

// File: bench/civil_date_to_epoch_ms_unit_test.sv
`timescale 1ns / 1ps

module civil_date_to_epoch_ms_unit_test
   import cdte_pkg::*;
();

   localparam int unsigned STALL_LIMIT = 25000;
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned PHASE_COUNT = 7;
   localparam int unsigned PHASE_BASE [PHASE_COUNT] = '{2000, 1970, 2100, 0, 4095, 0, 0};
   localparam int unsigned PHASE_ITEMS [PHASE_COUNT] = '{500, 300, 300, 300, 12, 350, 40};

   typedef struct packed {
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] yy;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] milli;
   } date_stamp_type;

   typedef struct {
      logic [11:0]     base;
      date_stamp_type  stamp;
      bit              fixed;
      logic [MS_W-1:0] fixed_ms;
   } directed_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic [4:0]      req_day_of_month = '0;
   logic [3:0]      req_month_number = '0;
   logic [6:0]      req_two_digit_year = '0;
   logic [4:0]      req_hour_of_day = '0;
   logic [5:0]      req_minute_of_hour = '0;
   logic [5:0]      req_second_of_minute = '0;
   logic [9:0]      req_millisecond_part = '0;
   logic            csr_write_enable = 1'b0;
   logic [11:0]     csr_write_data = '0;
   logic            rsp_valid;
   logic [MS_W-1:0] rsp_epoch_ms;

   logic [MS_W-1:0]  pending_epoch_ms [$];
   directed_row_type directed_rows [$];
   logic [11:0]      base_year = 12'd2000;
   int unsigned      fail_count = 0;
   int unsigned      stall_cycles = 0;
   logic [MS_W-1:0]  want_ms;

   civil_date_to_epoch_ms_unit dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_day_of_month     (req_day_of_month),
      .req_month_number     (req_month_number),
      .req_two_digit_year   (req_two_digit_year),
      .req_hour_of_day      (req_hour_of_day),
      .req_minute_of_hour   (req_minute_of_hour),
      .req_second_of_minute (req_second_of_minute),
      .req_millisecond_part (req_millisecond_part),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_epoch_ms         (rsp_epoch_ms)
   );

   always #5 clock = ~clock;

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic logic [MS_W-1:0] epoch_ms_of(input logic [11:0] base,
                                                   input date_stamp_type s);
      logic [63:0] days;
      logic [63:0] total;
      int unsigned target_year;
      int unsigned last_month;
      int unsigned y;
      int unsigned m;
      days = 64'd0;
      target_year = int'(base) + int'(s.yy);
      for (y = 1970; y < target_year; y++) begin
         days += leap_year(y) ? 64'd366 : 64'd365;
      end
      last_month = (s.month > 4'd13) ? 13 : int'(s.month);
      for (m = 1; m < last_month; m++) begin
         days += 64'(MONTH_DAYS[m-1]);
         if (m == 2 && leap_year(target_year)) begin
            days += 64'd1;
         end
      end
      days = days + 64'(s.day) - 64'd1;
      total = days * 64'd86400000 + 64'(s.hour) * 64'd3600000
            + 64'(s.minute) * 64'd60000 + 64'(s.second) * 64'd1000 + 64'(s.milli);
      return total[MS_W-1:0];
   endfunction

   function automatic void add_row(input int unsigned base, input int unsigned d,
                                   input int unsigned mo, input int unsigned y,
                                   input int unsigned h, input int unsigned mi,
                                   input int unsigned sec, input int unsigned ms,
                                   input bit fixed, input logic [MS_W-1:0] fixed_ms);
      directed_row_type r;
      r.base = 12'(base);
      r.stamp = '{day: 5'(d), month: 4'(mo), yy: 7'(y), hour: 5'(h), minute: 6'(mi),
                  second: 6'(sec), milli: 10'(ms)};
      r.fixed = fixed;
      r.fixed_ms = fixed_ms;
      directed_rows.push_back(r);
   endfunction

   function automatic date_stamp_type random_stamp();
      date_stamp_type s;
      if ($urandom_range(0, 9) < 8) begin
         s.day = 5'($urandom_range(1, 31));
         s.month = 4'($urandom_range(1, 12));
         s.yy = 7'($urandom_range(0, 99));
         s.hour = 5'($urandom_range(0, 23));
         s.minute = 6'($urandom_range(0, 59));
         s.second = 6'($urandom_range(0, 60));
         s.milli = 10'($urandom_range(0, 999));
      end else begin
         s = date_stamp_type'(43'({$urandom(), $urandom()}));
      end
      return s;
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 80);
   endfunction

   task automatic send_stamp(input date_stamp_type s, input logic [MS_W-1:0] want);
      req_day_of_month <= s.day;
      req_month_number <= s.month;
      req_two_digit_year <= s.yy;
      req_hour_of_day <= s.hour;
      req_minute_of_hour <= s.minute;
      req_second_of_minute <= s.second;
      req_millisecond_part <= s.milli;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_epoch_ms.push_back(want);
   endtask

   task automatic pause(input int unsigned cycles);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_epoch_ms.size() != 0) @(posedge clock);
   endtask

   task automatic set_century_base(input logic [11:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      base_year = value;
   endtask

   // result checking and the stall watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_epoch_ms.size() == 0) begin
            $error("rsp_epoch_ms unexpected: expected none, actual %0d", rsp_epoch_ms);
            fail_count++;
         end else begin
            want_ms = pending_epoch_ms.pop_front();
            if (rsp_epoch_ms !== want_ms) begin
               $error("rsp_epoch_ms mismatch: expected %0d, actual %0d", want_ms, rsp_epoch_ms);
               fail_count++;
            end
         end
      end
      // count cycles without any transfer
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      date_stamp_type   stamp;
      logic [11:0]      next_base;
      int unsigned      i;
      int unsigned      p;
      int unsigned      n;
      bit               quiet;

      add_row(2000, 1, 1, 0, 0, 0, 0, 0, 1, 43'd946684800000);
      add_row(2000, 31, 15, 127, 31, 63, 63, 1023, 0, '0);
      add_row(2000, 0, 0, 0, 0, 0, 0, 0, 0, '0);
      add_row(2000, 29, 2, 24, 12, 30, 30, 500, 0, '0);
      add_row(2000, 1, 3, 0, 0, 0, 0, 0, 0, '0);
      add_row(2000, 1, 3, 100, 0, 0, 0, 0, 0, '0);
      add_row(2000, 1, 3, 4, 0, 0, 0, 0, 0, '0);
      add_row(2000, 1, 3, 1, 0, 0, 0, 0, 0, '0);
      add_row(2000, 15, 13, 99, 23, 59, 60, 999, 0, '0);
      add_row(2000, 1, 1, 1, 23, 59, 59, 999, 0, '0);
      add_row(1970, 1, 1, 0, 0, 0, 0, 0, 1, '0);
      add_row(1970, 0, 1, 0, 0, 0, 0, 0, 1, 43'd8796006622208);
      add_row(1970, 31, 12, 99, 23, 59, 59, 999, 0, '0);
      add_row(0, 15, 6, 99, 10, 20, 30, 400, 0, '0);
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 43'd8796006622208);
      add_row(2100, 31, 12, 99, 23, 59, 60, 999, 1, 43'd7258118400999);
      add_row(2100, 29, 2, 0, 6, 0, 0, 1, 0, '0);
      add_row(4095, 31, 15, 127, 31, 63, 63, 1023, 0, '0);
      add_row(4095, 1, 1, 0, 0, 0, 0, 0, 0, '0);
      add_row(2000, 10, 7, 50, 0, 0, 0, 0, 0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.base != base_year) begin
            wait_for_results();
            set_century_base(row.base);
         end
         send_stamp(row.stamp, row.fixed ? row.fixed_ms : epoch_ms_of(base_year, row.stamp));
         pause(idle_gap());
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         quiet = (p == 1);
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            if (n == 0 || (p >= 5 && n % 25 == 0)) begin
               if (p == 5) begin
                  next_base = 12'($urandom_range(1970, 2100));
               end else if (p == 6) begin
                  next_base = 12'($urandom_range(0, 4095));
               end else begin
                  next_base = 12'(PHASE_BASE[p]);
               end
               wait_for_results();
               set_century_base(next_base);
            end else if ($urandom_range(0, 59) == 0) begin
               wait_for_results();
            end
            stamp = random_stamp();
            send_stamp(stamp, epoch_ms_of(base_year, stamp));
            if (!quiet) begin
               pause(idle_gap());
            end
         end
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/cdte_pkg.sv
rtl/core/civil_date_to_epoch_ms_unit.sv
bench/civil_date_to_epoch_ms_unit_test.sv
